// ----- hw/rtl/mvn_pkg.sv -----
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types and constants of the vertex normal engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvn_pkg;

    localparam int IDX_W = 10;  // vertex index
    localparam int POS_W = 24;  // Q11.12 coordinate
    localparam int CNT_W = 11;  // vertex_count register
    localparam int NRM_W = 16;  // Q1.15 normal component
    localparam int ACC_W = 64;  // accumulator component
    localparam int DIF_W = 25;  // edge vector component
    localparam int CRS_W = 52;  // cross product component

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_ADD   = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_ZERO  = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_ADD   = 3'd1,
        OP_QUERY = 3'd2,
        OP_NONE  = 3'd3,
        OP_RANGE = 3'd4
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/mvn_in_if.sv -----
// ----------------------------------------------------------------------------
// mvn_in_if
// Command channel: valid/ready handshake with one mesh command per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mvn_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      mode;
    logic [mvn_pkg::IDX_W-1:0]        index;
    logic signed [mvn_pkg::POS_W-1:0] pos_x;
    logic signed [mvn_pkg::POS_W-1:0] pos_y;
    logic signed [mvn_pkg::POS_W-1:0] pos_z;
    logic [mvn_pkg::IDX_W-1:0]        corner_a;
    logic [mvn_pkg::IDX_W-1:0]        corner_b;
    logic [mvn_pkg::IDX_W-1:0]        corner_c;

    modport source (output valid, mode, index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, mode, index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mvn_out_if.sv -----
// ----------------------------------------------------------------------------
// mvn_out_if
// Result channel: valid/ready handshake with status and unit normal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mvn_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic signed [mvn_pkg::NRM_W-1:0] norm_x;
    logic signed [mvn_pkg::NRM_W-1:0] norm_y;
    logic signed [mvn_pkg::NRM_W-1:0] norm_z;

    modport source (output valid, status, norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, status, norm_x, norm_y, norm_z, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mesh_vertex_normal_engine_top.sv -----
// Area-weighted vertex normal engine. Commands arrive on i_in (load vertex, add
// triangle, query normal) and each produces exactly one result on o_out. A
// two-entry queue lets commands be taken while the execution unit is busy.
// A load writes the vertex and clears its accumulator; a rejected/unused command
// goes straight to the result. A triangle takes three vertex reads, six
// multiplies on one shared multiplier and three accumulator read-modify-writes.
// A query runs the one-bit-pair-per-cycle square root and then the bit-serial
// dividers (all three components in parallel). After reset the accumulator
// memory is cleared one entry per cycle, all MAX_VERTICES entries, during
// which i_in.ready stays low; vertex_count may be written at any time.
// ----------------------------------------------------------------------------
// mesh_vertex_normal_engine_top
// Top level: front end, command queue and execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mesh_vertex_normal_engine_top #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mvn_pkg::CNT_W-1:0] i_cfg_wdata,
    mvn_in_if.sink                         i_in,
    mvn_out_if.source                      o_out
);
    import mvn_pkg::*;

    logic push, full, pop, q_valid, clear_busy;
    t_cmd push_cmd, q_cmd;

    mvn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(i_in), .i_full(full), .i_clear_busy(clear_busy),
        .o_push(push), .o_cmd(push_cmd)
    );

    mvn_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(push_cmd), .o_full(full),
        .i_pop(pop), .o_valid(q_valid), .o_data(q_cmd)
    );

    mvn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(pop),
        .o_clear_busy(clear_busy), .o_out(o_out)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mvn_ram.sv -----
// ----------------------------------------------------------------------------
// mvn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/mvn_front.sv -----
// ----------------------------------------------------------------------------
// mvn_front
// Accepts commands, holds vertex_count and classifies each command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvn_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mvn_pkg::CNT_W-1:0] i_cfg_wdata,
    mvn_in_if.sink                         i_in,
    input  wire logic                      i_full,
    input  wire logic                      i_clear_busy,
    output logic                           o_push,
    output mvn_pkg::t_cmd                  o_cmd
);
    import mvn_pkg::*;

    logic [CNT_W-1:0] r_vcount;
    logic             idx_ok;
    logic             tri_ok;

    function automatic logic f_ok(input logic [IDX_W-1:0] v, input logic [CNT_W-1:0] cnt);
        f_ok = ({1'b0, v} < cnt) && (32'(v) < MAX_VERTICES);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    assign idx_ok = f_ok(i_in.index, r_vcount);
    assign tri_ok = f_ok(i_in.corner_a, r_vcount) && f_ok(i_in.corner_b, r_vcount)
                    && f_ok(i_in.corner_c, r_vcount);

    always_comb begin
        o_cmd.index    = i_in.index;
        o_cmd.pos_x    = i_in.pos_x;
        o_cmd.pos_y    = i_in.pos_y;
        o_cmd.pos_z    = i_in.pos_z;
        o_cmd.corner_a = i_in.corner_a;
        o_cmd.corner_b = i_in.corner_b;
        o_cmd.corner_c = i_in.corner_c;
        case (i_in.mode)
            MODE_LOAD:  o_cmd.op = idx_ok ? OP_LOAD : OP_RANGE;
            MODE_ADD:   o_cmd.op = tri_ok ? OP_ADD : OP_RANGE;
            MODE_QUERY: o_cmd.op = idx_ok ? OP_QUERY : OP_RANGE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    // hold off while the accumulators are being cleared
    assign i_in.ready = !i_full && !i_clear_busy;
    assign o_push     = i_in.valid && i_in.ready;

endmodule

`default_nettype wire

// ----- hw/rtl/mvn_fifo.sv -----
// ----------------------------------------------------------------------------
// mvn_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvn_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mvn_pkg::t_cmd      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output mvn_pkg::t_cmd      o_data
);
    import mvn_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/mvn_back.sv -----
// ----------------------------------------------------------------------------
// mvn_back
// Executes commands: vertex/accumulator memories, cross product, saturating
// accumulate, and normalization with iterative square root and division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvn_back #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  mvn_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clear_busy,
    mvn_out_if.source     o_out
);
    import mvn_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VW    = 3 * POS_W;
    localparam int AWD   = 3 * ACC_W;
    localparam int PRD_W = 2 * DIF_W;
    localparam int RW    = 30;       // normalized magnitude
    localparam int SQ_W  = 63;       // square root working width
    localparam int LEN_W = 31;
    localparam int REM_W = 32;
    localparam int Q_W   = 17;
    localparam int N_W   = RW + 16;  // dividend width
    localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_LOAD   = 16'h0004,
        S_RDV    = 16'h0008,
        S_CROSS  = 16'h0010,
        S_ACC_RD = 16'h0020,
        S_ACC_WR = 16'h0040,
        S_Q_RD   = 16'h0080,
        S_Q_MAG  = 16'h0100,
        S_NORM   = 16'h0200,
        S_SQSUM  = 16'h0400,
        S_SQRT   = 16'h0800,
        S_DIVI   = 16'h1000,
        S_DIV    = 16'h2000,
        S_QOUT   = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [5:0]    r_cnt;
    logic [AW-1:0] r_clr;

    logic signed [POS_W-1:0] r_va [3];
    logic signed [DIF_W-1:0] r_u  [3];
    logic signed [DIF_W-1:0] r_v  [3];
    logic signed [PRD_W-1:0] r_prod;
    logic signed [CRS_W-1:0] r_n  [3];

    logic [2:0]       r_neg;
    logic [ACC_W-1:0] r_mag [3];
    logic [2*RW-1:0]  r_sq;
    logic [SQ_W-1:0]  r_rn;
    logic [SQ_W-1:0]  r_res;
    logic [SQ_W-1:0]  r_bit;
    logic [LEN_W-1:0] r_len;
    logic [REM_W-1:0] r_rem [3];
    logic [Q_W-1:0]   r_dq  [3];

    t_status          r_rs_status;
    logic [NRM_W-1:0] r_rs_n [3];
    logic             r_ov;
    t_status          r_o_status;
    logic [NRM_W-1:0] r_o_n [3];

    logic             v_we, a_we;
    logic [AW-1:0]    v_waddr, v_raddr, a_waddr, a_raddr;
    logic [VW-1:0]    v_wdata, v_rdata;
    logic [AWD-1:0]   a_wdata, a_rdata;

    logic [IDX_W-1:0]        corner;
    logic signed [POS_W-1:0] vrd [3];
    logic signed [DIF_W-1:0] mul_a, mul_b;
    logic [RW-1:0]           sq_op;
    logic [ACC_W-1:0]        mmax;
    logic [SQ_W-1:0]         rt_try;
    logic [LEN_W-1:0]        len;

    function automatic logic [ACC_W-1:0] f_sat(input logic [ACC_W-1:0] a,
                                               input logic [CRS_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-CRS_W){b[CRS_W-1]}}, b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            f_sat = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            f_sat = s[ACC_W-1:0];
        end
    endfunction

    // round-to-nearest quotient to Q1.15 with sign and saturation
    function automatic logic [NRM_W-1:0] f_q15(input logic neg, input logic [Q_W-1:0] q);
        logic big;
        big = (q >= Q_W'(32768));
        if (neg) begin
            f_q15 = big ? {1'b1, {(NRM_W-1){1'b0}}} : (~q[NRM_W-1:0] + 1'b1);
        end else begin
            f_q15 = big ? {1'b0, {(NRM_W-1){1'b1}}} : q[NRM_W-1:0];
        end
    endfunction

    mvn_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vert_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    mvn_ram #(.WIDTH(AWD), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    corner = r_cmd.corner_a;
            2'd1:    corner = r_cmd.corner_b;
            default: corner = r_cmd.corner_c;
        endcase
        for (int j = 0; j < 3; j++) begin
            vrd[j] = v_rdata[j*POS_W +: POS_W];
        end
        case (r_cnt[2:0])
            3'd0:    begin mul_a = r_u[1]; mul_b = r_v[2]; end
            3'd1:    begin mul_a = r_u[2]; mul_b = r_v[1]; end
            3'd2:    begin mul_a = r_u[2]; mul_b = r_v[0]; end
            3'd3:    begin mul_a = r_u[0]; mul_b = r_v[2]; end
            3'd4:    begin mul_a = r_u[0]; mul_b = r_v[1]; end
            default: begin mul_a = r_u[1]; mul_b = r_v[0]; end
        endcase
        case (r_cnt[1:0])
            2'd0:    sq_op = r_mag[0][RW-1:0];
            2'd1:    sq_op = r_mag[1][RW-1:0];
            default: sq_op = r_mag[2][RW-1:0];
        endcase
        mmax = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
        if (r_mag[2] > mmax) begin
            mmax = r_mag[2];
        end
        rt_try = r_res + r_bit;
        len    = r_res[LEN_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        v_we    = 1'b0;
        v_waddr = AW'(r_cmd.index);
        v_wdata = {r_cmd.pos_z, r_cmd.pos_y, r_cmd.pos_x};
        v_raddr = AW'(corner);
        a_we    = 1'b0;
        a_waddr = AW'(r_cmd.index);
        a_wdata = '0;
        a_raddr = AW'(r_cmd.index);
        case (r_state)
            S_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = r_clr;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_LOAD:  n_state = S_LOAD;
                        OP_ADD:   n_state = S_RDV;
                        OP_QUERY: n_state = S_Q_RD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                v_we    = 1'b1;
                a_we    = 1'b1;
                n_state = S_DONE;
            end
            S_RDV: begin
                if (r_cnt == 6'd3) begin
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                if (r_cnt == 6'd6) begin
                    n_state = S_ACC_RD;
                end
            end
            S_ACC_RD: begin
                a_raddr = AW'(corner);
                n_state = S_ACC_WR;
            end
            S_ACC_WR: begin
                a_we    = 1'b1;
                a_waddr = AW'(corner);
                for (int j = 0; j < 3; j++) begin
                    a_wdata[j*ACC_W +: ACC_W] = f_sat(a_rdata[j*ACC_W +: ACC_W], r_n[j]);
                end
                n_state = (r_cnt == 6'd2) ? S_DONE : S_ACC_RD;
            end
            S_Q_RD:  n_state = S_Q_MAG;
            S_Q_MAG: n_state = S_NORM;
            S_NORM: begin
                if (mmax == '0) begin
                    n_state = S_DONE;
                end else if (!(|mmax[ACC_W-1:RW]) && mmax[RW-1]) begin
                    n_state = S_SQSUM;
                end
            end
            S_SQSUM: begin
                if (r_cnt == 6'd3) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_bit[0]) begin
                    n_state = S_DIVI;
                end
            end
            S_DIVI: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 6'(Q_W - 1)) begin
                    n_state = S_QOUT;
                end
            end
            S_QOUT: n_state = S_DONE;
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd       <= i_cmd;
                        r_cnt       <= '0;
                        r_rs_status <= (i_cmd.op == OP_RANGE) ? ST_RANGE : ST_OK;
                        for (int j = 0; j < 3; j++) begin
                            r_rs_n[j] <= '0;
                        end
                    end
                end
                S_RDV: begin
                    r_cnt <= r_cnt + 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        case (r_cnt[1:0])
                            2'd1: r_va[j] <= vrd[j];
                            2'd2: r_u[j]  <= DIF_W'(vrd[j]) - DIF_W'(r_va[j]);
                            2'd3: r_v[j]  <= DIF_W'(vrd[j]) - DIF_W'(r_va[j]);
                            default: ;
                        endcase
                    end
                    if (r_cnt == 6'd3) begin
                        r_cnt <= '0;
                    end
                end
                S_CROSS: begin
                    r_prod <= mul_a * mul_b;
                    r_cnt  <= (r_cnt == 6'd6) ? 6'd0 : r_cnt + 1'b1;
                    // even products seed a component, odd ones subtract
                    case (r_cnt[2:0])
                        3'd1: r_n[0] <= CRS_W'(r_prod);
                        3'd2: r_n[0] <= r_n[0] - CRS_W'(r_prod);
                        3'd3: r_n[1] <= CRS_W'(r_prod);
                        3'd4: r_n[1] <= r_n[1] - CRS_W'(r_prod);
                        3'd5: r_n[2] <= CRS_W'(r_prod);
                        3'd6: r_n[2] <= r_n[2] - CRS_W'(r_prod);
                        default: ;
                    endcase
                end
                S_ACC_WR: r_cnt <= r_cnt + 1'b1;
                S_Q_MAG: begin
                    for (int j = 0; j < 3; j++) begin
                        r_neg[j] <= a_rdata[j*ACC_W + ACC_W - 1];
                        r_mag[j] <= a_rdata[j*ACC_W + ACC_W - 1]
                                    ? (~a_rdata[j*ACC_W +: ACC_W] + 1'b1)
                                    : a_rdata[j*ACC_W +: ACC_W];
                    end
                end
                S_NORM: begin
                    r_cnt <= '0;
                    if (mmax == '0) begin
                        r_rs_status <= ST_ZERO;
                    end
                    // walk the largest magnitude into [2^29, 2^30)
                    for (int j = 0; j < 3; j++) begin
                        if (|mmax[ACC_W-1:RW+7]) begin
                            r_mag[j] <= r_mag[j] >> 8;
                        end else if (|mmax[RW+6:RW]) begin
                            r_mag[j] <= r_mag[j] >> 1;
                        end else if (!(|mmax[RW-1:RW-9])) begin
                            r_mag[j] <= r_mag[j] << 8;
                        end else if (!mmax[RW-1]) begin
                            r_mag[j] <= r_mag[j] << 1;
                        end
                    end
                end
                S_SQSUM: begin
                    r_sq  <= sq_op * sq_op;
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt[1:0])
                        2'd1: r_rn <= SQ_W'(r_sq);
                        2'd2: r_rn <= r_rn + SQ_W'(r_sq);
                        2'd3: begin
                            r_rn  <= r_rn + SQ_W'(r_sq);
                            r_res <= '0;
                            r_bit <= {1'b1, {(SQ_W-1){1'b0}}};
                        end
                        default: ;
                    endcase
                end
                S_SQRT: begin
                    if (r_rn >= rt_try) begin
                        r_rn  <= r_rn - rt_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                S_DIVI: begin
                    r_len <= len;
                    r_cnt <= '0;
                    for (int j = 0; j < 3; j++) begin
                        logic [N_W-1:0] num;
                        num      = {r_mag[j][RW-1:0], 16'd0} >> 1;
                        num      = num + N_W'(len[LEN_W-1:1]);
                        r_rem[j] <= REM_W'(num[N_W-1:Q_W]);
                        r_dq[j]  <= num[Q_W-1:0];
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        logic [REM_W-1:0] t;
                        t = {r_rem[j][REM_W-2:0], r_dq[j][Q_W-1]};
                        if (t >= REM_W'(r_len)) begin
                            r_rem[j] <= t - REM_W'(r_len);
                            r_dq[j]  <= {r_dq[j][Q_W-2:0], 1'b1};
                        end else begin
                            r_rem[j] <= t;
                            r_dq[j]  <= {r_dq[j][Q_W-2:0], 1'b0};
                        end
                    end
                end
                S_QOUT: begin
                    for (int j = 0; j < 3; j++) begin
                        r_rs_n[j] <= f_q15(r_neg[j], r_dq[j]);
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_rs_status;
                        r_o_n      <= r_rs_n;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_clear_busy = (r_state == S_CLEAR);
    assign o_out.valid  = r_ov;
    assign o_out.status = r_o_status;
    assign o_out.norm_x = r_o_n[0];
    assign o_out.norm_y = r_o_n[1];
    assign o_out.norm_z = r_o_n[2];

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop) else $error("command taken during clear");
    a_len_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVI) |-> (r_res[SQ_W-1:LEN_W] == '0 && r_res[LEN_W-1:LEN_W-2] != 2'b00))
        else $error("square root out of expected range");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status != ST_OK) |->
        (r_o_n[0] == '0 && r_o_n[1] == '0 && r_o_n[2] == '0))
        else $error("nonzero normal with error status");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vertex normal engine: vertex loads, triangle
// accumulation and normal queries against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import mvn_pkg::*;

    localparam int NVERT = 1024;
    localparam int WDOG_LIMIT = 200000;

    typedef struct {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        index;
        logic signed [POS_W-1:0] px, py, pz;
        logic [IDX_W-1:0]        ca, cb, cc;
    } t_item;

    typedef struct {
        t_status                 status;
        logic signed [NRM_W-1:0] nx, ny, nz;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;

    mvn_in_if  cmd_if();
    mvn_out_if res_if();

    mesh_vertex_normal_engine_top #(.MAX_VERTICES(NVERT)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (cmd_if.sink),
        .o_out      (res_if.source)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    int unsigned      vcount;
    logic signed [POS_W-1:0] vx_mem[NVERT], vy_mem[NVERT], vz_mem[NVERT];
    logic signed [63:0] ax_mem[NVERT], ay_mem[NVERT], az_mem[NVERT];
    bit               loaded[NVERT];

    t_item   pending_cmds[$];
    t_normal expected_normals[$];
    int      errors = 0;
    int      n_results = 0;
    int      n_ok_queries = 0;
    int      stim_done = 0;

    function automatic logic signed [63:0] sat_acc(logic signed [63:0] a,
                                                    logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [NRM_W-1:0] unit_comp(logic signed [63:0] c,
                                                           logic [63:0] r,
                                                           logic [63:0] len);
        logic [63:0] q;
        logic signed [63:0] s;
        q = (r * 64'd32768 + len / 2) / len;
        if (q > 32768) q = 32768;
        s = c < 0 ? -$signed(q) : $signed(q);
        if (s > 32767) s = 32767;
        return s[NRM_W-1:0];
    endfunction

    function automatic t_normal predict_normal(t_item it);
        t_normal o;
        int unsigned lim;
        logic signed [63:0] ux, uy, uz, wx, wy, wz, cx, cy, cz, a[3];
        logic [63:0] m[3], r[3], mx, len;
        int top, sh, k;
        int unsigned cr[3];
        o = '{ST_OK, 0, 0, 0};
        lim = vcount < NVERT ? vcount : NVERT;
        case (it.mode)
            MODE_LOAD: begin
                if (it.index >= lim) begin
                    o.status = ST_RANGE;
                end else begin
                    vx_mem[it.index] = it.px;
                    vy_mem[it.index] = it.py;
                    vz_mem[it.index] = it.pz;
                    ax_mem[it.index] = 0;
                    ay_mem[it.index] = 0;
                    az_mem[it.index] = 0;
                    loaded[it.index] = 1;
                end
            end
            MODE_ADD: begin
                cr = '{it.ca, it.cb, it.cc};
                if (cr[0] >= lim || cr[1] >= lim || cr[2] >= lim) begin
                    o.status = ST_RANGE;
                end else begin
                    ux = 64'(vx_mem[cr[1]]) - 64'(vx_mem[cr[0]]);
                    uy = 64'(vy_mem[cr[1]]) - 64'(vy_mem[cr[0]]);
                    uz = 64'(vz_mem[cr[1]]) - 64'(vz_mem[cr[0]]);
                    wx = 64'(vx_mem[cr[2]]) - 64'(vx_mem[cr[0]]);
                    wy = 64'(vy_mem[cr[2]]) - 64'(vy_mem[cr[0]]);
                    wz = 64'(vz_mem[cr[2]]) - 64'(vz_mem[cr[0]]);
                    cx = uy * wz - uz * wy;
                    cy = uz * wx - ux * wz;
                    cz = ux * wy - uy * wx;
                    for (k = 0; k < 3; k++) begin
                        ax_mem[cr[k]] = sat_acc(ax_mem[cr[k]], cx);
                        ay_mem[cr[k]] = sat_acc(ay_mem[cr[k]], cy);
                        az_mem[cr[k]] = sat_acc(az_mem[cr[k]], cz);
                    end
                end
            end
            MODE_QUERY: begin
                if (it.index >= lim) begin
                    o.status = ST_RANGE;
                end else begin
                    a = '{ax_mem[it.index], ay_mem[it.index], az_mem[it.index]};
                    for (k = 0; k < 3; k++) m[k] = a[k] < 0 ? -a[k] : a[k];
                    mx = m[0] > m[1] ? m[0] : m[1];
                    if (m[2] > mx) mx = m[2];
                    if (mx == 0) begin
                        o.status = ST_ZERO;
                    end else begin
                        top = 0;
                        while (top < 63 && (mx >> (top + 1)) != 0) top++;
                        sh = top - 29;
                        for (k = 0; k < 3; k++)
                            r[k] = sh >= 0 ? m[k] >> sh : m[k] << (-sh);
                        len = int_sqrt(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
                        if (len == 0) len = 1;
                        o.nx = unit_comp(a[0], r[0], len);
                        o.ny = unit_comp(a[1], r[1], len);
                        o.nz = unit_comp(a[2], r[2], len);
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_if.valid) expected_normals.push_back(predict_normal(pending_cmds.pop_front()));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                it = pending_cmds[0];
                cmd_if.valid    <= 1'b1;
                cmd_if.mode     <= it.mode;
                cmd_if.index    <= it.index;
                cmd_if.pos_x    <= it.px;
                cmd_if.pos_y    <= it.py;
                cmd_if.pos_z    <= it.pz;
                cmd_if.corner_a <= it.ca;
                cmd_if.corner_b <= it.cb;
                cmd_if.corner_c <= it.cc;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result checks
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_normal w;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (expected_normals.size() == 0) begin
                    report_mismatch("unexpected result", res_if.status, -1);
                end else begin
                    w = expected_normals.pop_front();
                    if (res_if.status != w.status) report_mismatch("status", res_if.status, w.status);
                    if (res_if.norm_x != w.nx) report_mismatch("norm_x", res_if.norm_x, w.nx);
                    if (res_if.norm_y != w.ny) report_mismatch("norm_y", res_if.norm_y, w.ny);
                    if (res_if.norm_z != w.nz) report_mismatch("norm_z", res_if.norm_z, w.nz);
                    if (w.status == ST_OK && (w.nx | w.ny | w.nz) != 0) n_ok_queries++;
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            // stall pattern: quiet stretch, then a periodic and random mix
            res_if.ready <= stall_phase < 30 ? 1'b1 :
                            stall_phase < 60 ? (stall_phase % 5 != 0) :
                            ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on accepted transactions
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("mesh_vertex_normal_engine_top regression: fail");
            $finish;
        end
    end

    initial begin
        cmd_if.valid = 1'b0; cmd_if.mode = '0; cmd_if.index = '0;
        cmd_if.pos_x = '0; cmd_if.pos_y = '0; cmd_if.pos_z = '0;
        cmd_if.corner_a = '0; cmd_if.corner_b = '0; cmd_if.corner_c = '0;
        res_if.ready = 1'b0;
    end

    function automatic t_item blank_item(logic [1:0] md);
        t_item it;
        it.mode = md; it.index = $urandom; it.px = $urandom; it.py = $urandom;
        it.pz = $urandom; it.ca = $urandom; it.cb = $urandom; it.cc = $urandom;
        return it;
    endfunction

    function automatic logic [IDX_W-1:0] pick_loaded(int unsigned lim);
        logic [IDX_W-1:0] i;
        do i = $urandom_range(0, lim - 1); while (!loaded[i]);
        return i;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
            default: return $urandom;
        endcase
    endfunction

    // push a command, keeping track of which indices the block will hold
    task automatic queue_cmd(t_item it);
        int unsigned lim;
        lim = vcount < NVERT ? vcount : NVERT;
        if (it.mode == MODE_LOAD && it.index < lim) loaded[it.index] = 1;
        pending_cmds.push_back(it);
    endtask

    task automatic drain_and_config(int unsigned val);
        while (pending_cmds.size() > 0 || expected_normals.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vcount = val;
    endtask

    initial begin
        t_item it;
        int unsigned lim, counts[5], p, k;
        for (k = 0; k < NVERT; k++) begin
            ax_mem[k] = 0; ay_mem[k] = 0; az_mem[k] = 0; loaded[k] = 0;
            vx_mem[k] = 0; vy_mem[k] = 0; vz_mem[k] = 0;
        end
        vcount = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty mesh, then a full-size mesh with corner cases
        drain_and_config(0);
        it = blank_item(MODE_LOAD); it.index = 0; queue_cmd(it);
        it = blank_item(MODE_QUERY); it.index = 0; queue_cmd(it);
        it = blank_item(MODE_ADD); it.ca = 0; it.cb = 0; it.cc = 0; queue_cmd(it);
        drain_and_config(2047);
        it = blank_item(MODE_LOAD); it.index = 0;
        it.px = 24'sh800000; it.py = 24'sh800000; it.pz = 24'sh800000; queue_cmd(it);
        it.index = 1; it.px = 24'sh7FFFFF; it.py = 24'sh800000; it.pz = 24'sh7FFFFF; queue_cmd(it);
        it.index = 1023; it.px = 24'sh800000; it.py = 24'sh7FFFFF; it.pz = 24'sh800000;
        queue_cmd(it);
        it = blank_item(MODE_QUERY); it.index = 1023; queue_cmd(it);  // zero sum
        it = blank_item(MODE_ADD); it.ca = 0; it.cb = 1; it.cc = 1023;
        for (k = 0; k < 6; k++) queue_cmd(it);  // drive toward saturation
        it = blank_item(MODE_QUERY); it.index = 0; queue_cmd(it);
        it.index = 1023; queue_cmd(it);
        it = blank_item(MODE_ADD); it.ca = 0; it.cb = 0; it.cc = 1; queue_cmd(it);
        it = blank_item(2'd3); queue_cmd(it);
        drain_and_config(1024);
        it = blank_item(MODE_QUERY); it.index = 1; queue_cmd(it);

        // random phases over several mesh sizes
        counts = '{3, 1025, 16, 300, 64};
        for (p = 0; p < 5; p++) begin
            drain_and_config(counts[p]);
            lim = vcount < NVERT ? vcount : NVERT;
            for (k = 0; k < 3; k++) begin
                it = blank_item(MODE_LOAD); it.index = $urandom_range(0, lim - 1);
                it.px = rand_pos(); it.py = rand_pos(); it.pz = rand_pos(); queue_cmd(it);
            end
            for (k = 0; k < 260; k++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: begin
                        it = blank_item(MODE_LOAD); it.index = $urandom_range(0, lim - 1);
                        it.px = rand_pos(); it.py = rand_pos(); it.pz = rand_pos();
                    end
                    4, 5, 6, 7, 8, 9, 10: begin
                        it = blank_item(MODE_ADD);
                        it.ca = pick_loaded(lim); it.cb = pick_loaded(lim);
                        it.cc = pick_loaded(lim);
                    end
                    11, 12, 13, 14, 15: begin
                        it = blank_item(MODE_QUERY); it.index = pick_loaded(lim);
                    end
                    16: it = blank_item(MODE_QUERY);  // any index, often out of range
                    17: begin
                        it = blank_item(MODE_ADD);
                        it.ca = pick_loaded(lim); it.cb = pick_loaded(lim);
                        it.cc = $urandom;
                        if (it.cc < lim && !loaded[it.cc]) it.cc = lim - 1 + (lim < NVERT);
                        if (it.cc < lim && !loaded[it.cc]) it.cc = pick_loaded(lim);
                    end
                    18: it = blank_item(MODE_LOAD);
                    default: it = blank_item(2'd3);
                endcase
                queue_cmd(it);
            end
        end
        drain_and_config(vcount);
        stim_done = 1;
    end

    initial begin
        wait (stim_done == 1);
        $display("covered %0d results, %0d nonzero normal queries, mesh sizes 0 to 2047",
                 n_results, n_ok_queries);
        if (errors == 0 && expected_normals.size() == 0)
            $display("mesh_vertex_normal_engine_top regression: pass");
        else
            $display("mesh_vertex_normal_engine_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/mvn_pkg.sv
hw/rtl/mvn_in_if.sv
hw/rtl/mvn_out_if.sv
hw/rtl/mvn_ram.sv
hw/rtl/mvn_front.sv
hw/rtl/mvn_fifo.sv
hw/rtl/mvn_back.sv
hw/rtl/mesh_vertex_normal_engine_top.sv
dv/tb.sv
